### sv/assert_macros.svh
// Assertion macros shared by the RTL of the statistics accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/psa_pkg.sv
// Types and constants shared by the statistics accumulator modules.
`default_nettype none

package psa_pkg;

    localparam int NUM_ENTRIES_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 32;
    localparam int VAL_W   = 32;
    localparam int IVL_W   = 16;
    localparam int TICK_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(10);

    // Register index taken from the word address of the configuration port.
    localparam logic [PADDR_W-3:0] REG_INTERVAL_LENGTH = '0;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_DIV_IVL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic        [CNT_W-1:0] count;
        logic signed [VAL_W-1:0] min_v;
        logic signed [VAL_W-1:0] max_v;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             clr_en;
        logic [IDX_W-1:0] clr_addr;
    } t_mem_ctrl;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic        [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

### sv/psa_mem.sv
// Entry memory with per-entry valid bits; an invalid entry reads as zero.
`default_nettype none

module psa_mem #(
    parameter int NUM_ENTRIES = psa_pkg::NUM_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psa_pkg::t_mem_ctrl     i_ctrl,
    input  psa_pkg::t_entry        i_wr_data,
    output psa_pkg::t_entry        o_rd_data,
    output logic [NUM_ENTRIES-1:0] o_valid
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    psa_pkg::t_entry        mem [NUM_ENTRIES];
    psa_pkg::t_entry        r_rd_data;
    logic                   r_rd_valid;
    logic [NUM_ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_ctrl.wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[i_ctrl.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.wr_en) begin
                r_valid[i_ctrl.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_ctrl.clr_en) begin
                r_valid[i_ctrl.clr_addr[AW-1:0]] <= 1'b0;
            end
            if (i_ctrl.rd_en) begin
                r_rd_valid <= r_valid[i_ctrl.rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;
    assign o_valid   = r_valid;

endmodule

`default_nettype wire

### sv/psa_div.sv
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`default_nettype none

module psa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psa_pkg::t_div_req               i_req,
    output logic                            o_done,
    output logic signed [psa_pkg::SUM_W-1:0] o_quotient
);

    localparam int SW = psa_pkg::SUM_W;
    localparam int CW = psa_pkg::CNT_W;

    logic [psa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [SW-1:0]                 r_quo;
    logic [CW-1:0]                 r_rem;
    logic [CW-1:0]                 r_div;
    logic                          r_neg;

    logic [SW-1:0] dvd_mag;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          fits;

    always_comb begin
        dvd_mag = i_req.dividend[SW-1] ? (~i_req.dividend + SW'(1)) : i_req.dividend;
        trial   = {r_rem, r_quo[SW-1]};
        diff    = trial - {1'b0, r_div};
        fits    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && (r_cnt == psa_pkg::DIV_CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= psa_pkg::DIV_CNT_W'(psa_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - psa_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // The dividend magnitude shifts out of the top of r_quo as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= dvd_mag;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[SW-1];
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[CW-1:0] : trial[CW-1:0];
            r_quo <= {r_quo[SW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(~r_quo + SW'(1)) : $signed(r_quo);

endmodule

`default_nettype wire

### sv/periodic_statistics_accumulator.sv
// Top level of the periodic statistics accumulator. A tick only counts up the elapsed
// ticks. For a sample, the entry is read from the single statistics memory in the
// accepting cycle and written back in the next, during which input is stalled. When a
// sample finds more ticks elapsed than the interval length, the block walks the entries
// in index order: an empty entry is skipped in the scan state, and a reported entry is
// loaded, then the bit-serial divider forms first the per-sample and then the
// per-interval mean at one quotient bit per cycle, and the emit state waits on any output stall.
// Input is stalled for the whole report. Entries are emptied by per-entry valid bits,
// so there is no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module periodic_statistics_accumulator #(
    parameter int NUM_ENTRIES = psa_pkg::NUM_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic        [psa_pkg::IDX_W-1:0]  i_entry_index,
    input  logic signed [psa_pkg::VAL_W-1:0]  i_sample_value,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic        [psa_pkg::IDX_W-1:0]  o_report_index,
    output logic signed [psa_pkg::SUM_W-1:0]  o_total_sum,
    output logic        [psa_pkg::CNT_W-1:0]  o_sample_count,
    output logic signed [psa_pkg::VAL_W-1:0]  o_mean_per_sample,
    output logic signed [psa_pkg::SUM_W-1:0]  o_mean_per_interval,
    output logic signed [psa_pkg::VAL_W-1:0]  o_min_value,
    output logic signed [psa_pkg::VAL_W-1:0]  o_max_value,
    output logic                              o_last_flag,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic        [psa_pkg::PADDR_W-1:0] paddr,
    input  logic        [psa_pkg::PDATA_W-1:0] pwdata,
    output logic        [psa_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int IW = psa_pkg::IDX_W;
    localparam int SW = psa_pkg::SUM_W;
    localparam int CW = psa_pkg::CNT_W;
    localparam int VW = psa_pkg::VAL_W;
    localparam int TW = psa_pkg::TICK_W;
    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    localparam logic [IW:0]   NUM_LIM  = (IW + 1)'(NUM_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [SW-1:0] MPS_MAX = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [SW-1:0] MPS_MIN = {{(SW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

    psa_pkg::t_state           r_state, n_state;
    logic [psa_pkg::IVL_W-1:0] r_interval;
    logic [TW-1:0]             r_elapsed;
    logic [IW-1:0]             r_idx;
    logic signed [VW-1:0]      r_val;
    logic [IW-1:0]             r_walk;
    psa_pkg::t_entry           r_ent;
    logic signed [VW-1:0]      r_mps;

    logic                      r_out_valid;
    logic [IW-1:0]             r_out_index;
    logic signed [SW-1:0]      r_out_sum;
    logic [CW-1:0]             r_out_count;
    logic signed [VW-1:0]      r_out_mps;
    logic signed [SW-1:0]      r_out_mpi;
    logic signed [VW-1:0]      r_out_min;
    logic signed [VW-1:0]      r_out_max;
    logic                      r_out_last;

    psa_pkg::t_mem_ctrl        mem_ctrl;
    psa_pkg::t_entry           mem_rd;
    psa_pkg::t_entry           upd_ent;
    logic [NUM_ENTRIES-1:0]    mem_valid;
    psa_pkg::t_div_req         div_req;
    logic                      div_done;
    logic signed [SW-1:0]      div_q;

    logic                      in_acc;
    logic                      in_range;
    logic                      take_sample;
    logic                      rpt_due;
    logic                      cur_valid;
    logic                      any_above;
    logic                      emit_go;
    logic                      rpt_end;
    logic [CW-1:0]             div_ivl;
    logic signed [VW-1:0]      mps_sat;
    logic signed [SW:0]        sum_ext;
    logic signed [VW-1:0]      base_min;
    logic signed [VW-1:0]      base_max;
    logic                      cfg_wr;
    logic                      cfg_sel;

    // Configuration port.
    assign cfg_sel = (paddr[psa_pkg::PADDR_W-1:2] == psa_pkg::REG_INTERVAL_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? psa_pkg::PDATA_W'(r_interval) : '0;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_range    = {1'b0, i_entry_index} < NUM_LIM;
    assign take_sample = in_acc && (i_cmd == psa_pkg::CMD_SAMPLE) && in_range;
    assign rpt_due     = r_elapsed > TW'(r_interval);
    assign cur_valid   = mem_valid[r_walk[AW-1:0]];
    assign emit_go     = (r_state == psa_pkg::ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign div_ivl     = (r_interval == '0) ? CW'(1) : CW'(r_interval);
    assign rpt_end     = (emit_go && !any_above)
                      || ((r_state == psa_pkg::ST_SCAN) && !cur_valid && (r_walk == LAST_IDX));

    always_comb begin
        any_above = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (mem_valid[i] && (IW'(i) > r_walk)) begin
                any_above = 1'b1;
            end
        end
    end

    // Sample update; an entry read with a zero count takes the sample as both extremes.
    always_comb begin
        base_min = (mem_rd.count == '0) ? r_val : mem_rd.min_v;
        base_max = (mem_rd.count == '0) ? r_val : mem_rd.max_v;
        upd_ent.count = (&mem_rd.count) ? mem_rd.count : mem_rd.count + CW'(1);
        upd_ent.max_v = base_max;
        upd_ent.min_v = base_min;
        if (r_val > base_max) begin
            upd_ent.max_v = r_val;
        end else if (r_val < base_min) begin
            upd_ent.min_v = r_val;
        end
        sum_ext = {mem_rd.sum[SW-1], mem_rd.sum} + {{(SW - VW + 1){r_val[VW-1]}}, r_val};
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            upd_ent.sum = sum_ext[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            upd_ent.sum = sum_ext[SW-1:0];
        end
    end

    always_comb begin
        if (div_q > MPS_MAX) begin
            mps_sat = MPS_MAX[VW-1:0];
        end else if (div_q < MPS_MIN) begin
            mps_sat = MPS_MIN[VW-1:0];
        end else begin
            mps_sat = div_q[VW-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psa_pkg::ST_IDLE: begin
                if (take_sample) begin
                    n_state = psa_pkg::ST_UPDATE;
                end
            end
            psa_pkg::ST_UPDATE: begin
                n_state = rpt_due ? psa_pkg::ST_SCAN : psa_pkg::ST_IDLE;
            end
            psa_pkg::ST_SCAN: begin
                if (cur_valid) begin
                    n_state = psa_pkg::ST_LOAD;
                end else if (r_walk == LAST_IDX) begin
                    n_state = psa_pkg::ST_IDLE;
                end
            end
            psa_pkg::ST_LOAD: begin
                n_state = psa_pkg::ST_DIV_MEAN;
            end
            psa_pkg::ST_DIV_MEAN: begin
                if (div_done) begin
                    n_state = psa_pkg::ST_DIV_IVL;
                end
            end
            psa_pkg::ST_DIV_IVL: begin
                if (div_done) begin
                    n_state = psa_pkg::ST_EMIT;
                end
            end
            psa_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = any_above ? psa_pkg::ST_SCAN : psa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psa_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: memory and divider control, input stall.
    always_comb begin
        mem_ctrl   = '0;
        div_req    = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            psa_pkg::ST_IDLE: begin
                o_in_stall       = 1'b0;
                mem_ctrl.rd_en   = take_sample;
                mem_ctrl.rd_addr = i_entry_index;
            end
            psa_pkg::ST_UPDATE: begin
                mem_ctrl.wr_en   = 1'b1;
                mem_ctrl.wr_addr = r_idx;
            end
            psa_pkg::ST_SCAN: begin
                mem_ctrl.rd_en   = cur_valid;
                mem_ctrl.rd_addr = r_walk;
            end
            psa_pkg::ST_LOAD: begin
                div_req.start    = 1'b1;
                div_req.dividend = mem_rd.sum;
                div_req.divisor  = mem_rd.count;
            end
            psa_pkg::ST_DIV_MEAN: begin
                div_req.start    = div_done;
                div_req.dividend = r_ent.sum;
                div_req.divisor  = div_ivl;
            end
            psa_pkg::ST_DIV_IVL: begin
            end
            psa_pkg::ST_EMIT: begin
                mem_ctrl.clr_en   = emit_go;
                mem_ctrl.clr_addr = r_walk;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psa_pkg::ST_IDLE;
            r_interval  <= psa_pkg::INTERVAL_RESET;
            r_elapsed   <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && cfg_sel) begin
                r_interval <= pwdata[psa_pkg::IVL_W-1:0];
            end
            if (rpt_end) begin
                r_elapsed <= '0;
            end else if (in_acc && (i_cmd == psa_pkg::CMD_TICK) && !(&r_elapsed)) begin
                r_elapsed <= r_elapsed + TW'(1);
            end
            if ((r_state == psa_pkg::ST_UPDATE) && rpt_due) begin
                r_walk <= '0;
            end else if (((r_state == psa_pkg::ST_SCAN) && !cur_valid && (r_walk != LAST_IDX))
                      || (emit_go && any_above)) begin
                r_walk <= r_walk + IW'(1);
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_idx <= i_entry_index;
            r_val <= i_sample_value;
        end
        if (r_state == psa_pkg::ST_LOAD) begin
            r_ent <= mem_rd;
        end
        if ((r_state == psa_pkg::ST_DIV_MEAN) && div_done) begin
            r_mps <= mps_sat;
        end
        if (emit_go) begin
            r_out_index <= r_walk;
            r_out_sum   <= r_ent.sum;
            r_out_count <= r_ent.count;
            r_out_mps   <= r_mps;
            r_out_mpi   <= div_q;
            r_out_min   <= r_ent.min_v;
            r_out_max   <= r_ent.max_v;
            r_out_last  <= !any_above;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_report_index      = r_out_index;
    assign o_total_sum         = r_out_sum;
    assign o_sample_count      = r_out_count;
    assign o_mean_per_sample   = r_out_mps;
    assign o_mean_per_interval = r_out_mpi;
    assign o_min_value         = r_out_min;
    assign o_max_value         = r_out_max;
    assign o_last_flag         = r_out_last;

    psa_mem #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mem_ctrl),
        .i_wr_data (upd_ent),
        .o_rd_data (mem_rd),
        .o_valid   (mem_valid)
    );

    psa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    `ASSERT_IMPLY(a_emit_nonzero, i_clk, i_rst_n, emit_go, r_ent.count != '0, "reported entry has zero count")
    `ASSERT_IMPLY(a_div_done_wait, i_clk, i_rst_n, div_done, (r_state == psa_pkg::ST_DIV_MEAN) || (r_state == psa_pkg::ST_DIV_IVL), "divider finished outside a wait state")
    `ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, emit_go && !any_above, (r_state == psa_pkg::ST_IDLE) && (r_elapsed == '0) && o_last_flag, "final report transaction did not close the report")

endmodule

`default_nettype wire
